// ----- rtl/core/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and codes shared by the fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // opcodes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MAX  = 4'd4;
    localparam logic [3:0] OP_INC  = 4'd5;
    localparam logic [3:0] OP_DEC  = 4'd6;
    localparam logic [3:0] OP_I2F  = 4'd7;
    localparam logic [3:0] OP_F2I  = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic signed [31:0] RAW_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;

    // request transfer
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_raw;
        logic signed [31:0] b_raw;
    } fpa_req_t;

    // result transfer
    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               greater;
        logic               less;
        logic               equal;
        logic [1:0]         status;
    } fpa_rsp_t;

    // operation context that travels down the divider chain
    typedef struct packed {
        logic               valid;
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        d;
        logic               neg;
    } fpa_side_t;

endpackage

// ----- rtl/core/fpa_div_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step: shifts one dividend bit into the partial
// remainder, produces one quotient bit and hands everything to the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
    parameter int NQ = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fpa_pkg::fpa_side_t  in_side,
    input  logic [NQ-1:0]       in_nq,
    input  logic [31:0]         in_rem,
    output fpa_pkg::fpa_side_t  out_side,
    output logic [NQ-1:0]       out_nq,
    output logic [31:0]         out_rem
);
    import fpa_pkg::*;

    fpa_side_t      side_reg;
    logic           valid_reg;
    logic [NQ-1:0]  nq_reg, nq_next;
    logic [31:0]    rem_reg, rem_next;
    logic [32:0]    rem_sh;
    logic [32:0]    rem_sub;
    logic           fits;

    // trial subtract
    always_comb
    begin
        rem_sh   = {in_rem, in_nq[NQ-1]};
        rem_sub  = rem_sh - {1'b0, in_side.d};
        fits     = (rem_sh >= {1'b0, in_side.d});
        rem_next = fits ? rem_sub[31:0] : rem_sh[31:0];
        nq_next  = {in_nq[NQ-2:0], fits};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_side.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        side_reg.op  <= in_side.op;
        side_reg.a   <= in_side.a;
        side_reg.b   <= in_side.b;
        side_reg.d   <= in_side.d;
        side_reg.neg <= in_side.neg;
        nq_reg       <= nq_next;
        rem_reg      <= rem_next;
    end

    assign out_side = '{valid: valid_reg, op: side_reg.op, a: side_reg.a, b: side_reg.b,
                        d: side_reg.d, neg: side_reg.neg};
    assign out_nq   = nq_reg;
    assign out_rem  = rem_reg;

endmodule

// ----- rtl/core/fpa_finish.sv -----
// ----------------------------------------------------------------------------
// fpa_finish
// Two closing stages: product and rounded quotient, then result select,
// saturation, compare flags and status.
// ----------------------------------------------------------------------------
module fpa_finish #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpa_pkg::fpa_side_t            in_side,
    input  logic [32+FRACTION_BITS-1:0]   in_quo,
    input  logic [31:0]                   in_rem,
    output logic                          done,
    output fpa_pkg::fpa_rsp_t             rsp
);
    import fpa_pkg::*;

    localparam int NQ = 32 + FRACTION_BITS;

    fpa_side_t          side_reg;
    logic               valid_reg;
    logic [63:0]        prod_reg;
    logic [NQ:0]        qr_reg;
    logic [31:0]        mag_a, mag_b;
    logic               round_up;
    logic               done_reg;
    fpa_rsp_t           rsp_reg, rsp_next;

    logic signed [32:0] sum33, dif33, inc33, dec33;
    logic [63:0]        mul_round, mul_mag;
    logic [32:0]        mul_sat, div_sat, add_sat, sub_sat, inc_sat, dec_sat;
    logic signed [31:0] i2f_top;

    // saturate a magnitude with a sign to 32 bits, overflow flag on top
    function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [32:0] r;
        if (neg)
        begin
            if (m > 64'h0000_0000_8000_0000)
                r = {1'b1, RAW_MIN};
            else
                r = {1'b0, 32'd0 - m[31:0]};
        end
        else
        begin
            if (m > 64'h0000_0000_7FFF_FFFF)
                r = {1'b1, RAW_MAX};
            else
                r = {1'b0, m[31:0]};
        end
        return r;
    endfunction

    // saturate a 33-bit signed sum
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31])
            r = {1'b1, (v[32] ? RAW_MIN : RAW_MAX)};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // first stage operands
    always_comb
    begin
        mag_a    = in_side.a[31] ? 32'd0 - in_side.a : in_side.a;
        mag_b    = in_side.b[31] ? 32'd0 - in_side.b : in_side.b;
        round_up = ({in_rem, 1'b0} >= {1'b0, in_side.d});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_side.valid;
            done_reg  <= valid_reg;
        end
    end

    // product and rounded quotient
    always_ff @(posedge clk)
    begin
        side_reg.op  <= in_side.op;
        side_reg.a   <= in_side.a;
        side_reg.b   <= in_side.b;
        side_reg.d   <= in_side.d;
        side_reg.neg <= in_side.neg;
        prod_reg     <= mag_a * mag_b;
        qr_reg       <= {1'b0, in_quo} + {{NQ{1'b0}}, round_up};
    end

    // result select and saturation
    always_comb
    begin
        sum33     = {side_reg.a[31], side_reg.a} + {side_reg.b[31], side_reg.b};
        dif33     = {side_reg.a[31], side_reg.a} - {side_reg.b[31], side_reg.b};
        inc33     = {side_reg.a[31], side_reg.a} + 33'sd1;
        dec33     = {side_reg.a[31], side_reg.a} - 33'sd1;
        add_sat   = sat33(sum33);
        sub_sat   = sat33(dif33);
        inc_sat   = sat33(inc33);
        dec_sat   = sat33(dec33);
        mul_round = prod_reg + (64'd1 << (FRACTION_BITS - 1));
        mul_mag   = mul_round >> FRACTION_BITS;
        mul_sat   = sat_mag(mul_mag, side_reg.neg);
        div_sat   = sat_mag(64'(qr_reg), side_reg.neg);
        i2f_top   = side_reg.a >>> (31 - FRACTION_BITS);

        rsp_next.greater = (side_reg.a > side_reg.b);
        rsp_next.less    = (side_reg.a < side_reg.b);
        rsp_next.equal   = (side_reg.a == side_reg.b);
        rsp_next.result_raw = 32'sd0;
        rsp_next.status     = ST_OK;

        case (side_reg.op)
            OP_ADD:
            begin
                rsp_next.result_raw = add_sat[31:0];
                rsp_next.status     = add_sat[32] ? ST_OVF : ST_OK;
            end
            OP_SUB:
            begin
                rsp_next.result_raw = sub_sat[31:0];
                rsp_next.status     = sub_sat[32] ? ST_OVF : ST_OK;
            end
            OP_MUL:
            begin
                rsp_next.result_raw = mul_sat[31:0];
                rsp_next.status     = mul_sat[32] ? ST_OVF : ST_OK;
            end
            OP_DIV:
            begin
                if (side_reg.d == 32'd0)
                begin
                    rsp_next.status = ST_DIVZ;
                    if (side_reg.a > 32'sd0)
                        rsp_next.result_raw = RAW_MAX;
                    else if (side_reg.a < 32'sd0)
                        rsp_next.result_raw = RAW_MIN;
                    else
                        rsp_next.result_raw = 32'sd0;
                end
                else
                begin
                    rsp_next.result_raw = div_sat[31:0];
                    rsp_next.status     = div_sat[32] ? ST_OVF : ST_OK;
                end
            end
            OP_MAX:
            begin
                rsp_next.result_raw = (side_reg.a > side_reg.b) ? side_reg.a : side_reg.b;
            end
            OP_INC:
            begin
                rsp_next.result_raw = inc_sat[31:0];
                rsp_next.status     = inc_sat[32] ? ST_OVF : ST_OK;
            end
            OP_DEC:
            begin
                rsp_next.result_raw = dec_sat[31:0];
                rsp_next.status     = dec_sat[32] ? ST_OVF : ST_OK;
            end
            OP_I2F:
            begin
                if (i2f_top != 32'sd0 && i2f_top != -32'sd1)
                begin
                    rsp_next.result_raw = side_reg.a[31] ? RAW_MIN : RAW_MAX;
                    rsp_next.status     = ST_OVF;
                end
                else
                begin
                    rsp_next.result_raw = side_reg.a <<< FRACTION_BITS;
                end
            end
            OP_F2I:
            begin
                rsp_next.result_raw = side_reg.a >>> FRACTION_BITS;
            end
            default:
            begin
                rsp_next.result_raw = 32'sd0;
                rsp_next.status     = ST_OK;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- rtl/core/fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed 32-bit fixed-point arithmetic unit, pipelined through a chain of
// restoring-division cells.
//
//   channel   ports              handshake
//   request   req (fpa_req_t)    start, taken when busy is low
//   result    rsp (fpa_rsp_t)    done, one-cycle strobe
//
// One request may be taken every cycle; busy never rises.
// The pipeline holds one entry stage, one division cell per quotient bit
// (32 + FRACTION_BITS), and two closing stages.
// Reset clears the valid bits of every stage; data registers are not reset.
// Results are not held: done and rsp last exactly one cycle.
// ----------------------------------------------------------------------------
module fixed_point_alu_top #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fpa_pkg::fpa_req_t  req,
    output logic               done,
    output fpa_pkg::fpa_rsp_t  rsp
);
    import fpa_pkg::*;

    localparam int NQ = 32 + FRACTION_BITS;

    fpa_side_t      chain_side [0:NQ];
    logic [NQ-1:0]  chain_nq   [0:NQ];
    logic [31:0]    chain_rem  [0:NQ];

    fpa_side_t      side_reg;
    logic           valid_reg;
    logic [NQ-1:0]  n_reg;
    logic [31:0]    mag_a, mag_b;

    // operand magnitudes
    always_comb
    begin
        mag_a = req.a_raw[31] ? 32'd0 - req.a_raw : req.a_raw;
        mag_b = req.b_raw[31] ? 32'd0 - req.b_raw : req.b_raw;
    end

    // entry stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start & ~busy;
        end
    end

    // entry stage payload
    always_ff @(posedge clk)
    begin
        side_reg.op  <= req.op;
        side_reg.a   <= req.a_raw;
        side_reg.b   <= req.b_raw;
        side_reg.d   <= mag_b;
        side_reg.neg <= req.a_raw[31] ^ req.b_raw[31];
        n_reg        <= {mag_a, {FRACTION_BITS{1'b0}}};
    end

    assign chain_side[0] = '{valid: valid_reg, op: side_reg.op, a: side_reg.a,
                             b: side_reg.b, d: side_reg.d, neg: side_reg.neg};
    assign chain_nq[0]   = n_reg;
    assign chain_rem[0]  = 32'd0;

    // division chain, one quotient bit per cell
    for (genvar i = 0; i < NQ; i++)
    begin : g_cell
        fpa_div_cell #(
            .NQ (NQ)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_side  (chain_side[i]),
            .in_nq    (chain_nq[i]),
            .in_rem   (chain_rem[i]),
            .out_side (chain_side[i+1]),
            .out_nq   (chain_nq[i+1]),
            .out_rem  (chain_rem[i+1])
        );
    end

    // rounding, select and saturation
    fpa_finish #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_side (chain_side[NQ]),
        .in_quo  (chain_nq[NQ]),
        .in_rem  (chain_rem[NQ]),
        .done    (done),
        .rsp     (rsp)
    );

    assign busy = 1'b0;

endmodule

// ----- rtl/core/fpa_checker.sv -----
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker #(
    parameter int FRACTION_BITS = 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input fpa_pkg::fpa_req_t  req,
    input logic               done,
    input fpa_pkg::fpa_rsp_t  rsp
);
    import fpa_pkg::*;

    localparam int LAT = 35 + FRACTION_BITS;

    // every transfer yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after request transfer");

    // no result without a request transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // exactly one compare flag
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({rsp.greater, rsp.less, rsp.equal}))
        else $error("compare flags not one-hot");

    // status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_OVF || rsp.status == ST_DIVZ))
        else $error("bad status code");

    // the unit never refuses a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind fixed_point_alu_top fpa_checker #(.FRACTION_BITS(FRACTION_BITS)) u_fpa_checker (.*);
